@@ sv/ccnp_pkg.sv @@
`default_nettype none
// ============================================================================
// ccnp_pkg
// Shared widths, operation codes, status codes and the command and status
// structures that join the controller to the datapath.
// ============================================================================
package ccnp_pkg;

    // Coordinate and radius widths.
    localparam int CW    = 32;
    localparam int RW    = CW - 2;
    // Centre difference, signed.
    localparam int DXW   = CW + 2;
    // Multiplier operand and product widths.
    localparam int MW    = CW + 4;
    localparam int PW    = 2 * MW;
    // Squared centre distance, squared radius sum and difference, and squared radius.
    localparam int DW    = 2 * CW + 3;
    localparam int SQW   = 2 * (CW - 1);
    localparam int RSQW  = 2 * RW;
    // Rounded centre distance.
    localparam int DVW   = CW;
    // Wide signed sums and dividends.
    localparam int NW    = 2 * CW;
    // Quotient and candidate point widths.
    localparam int QW    = CW + 2;
    localparam int SW    = CW + 4;
    // Squared distance to the old point.
    localparam int DSW   = PW + 1;
    // Running total.
    localparam int TW    = 32;

    localparam int OPW   = 5;

    localparam logic [OPW-1:0] OP_SQ_DX    = 5'd0;
    localparam logic [OPW-1:0] OP_SQ_DY    = 5'd1;
    localparam logic [OPW-1:0] OP_SQ_SUM   = 5'd2;
    localparam logic [OPW-1:0] OP_SQ_DIFF  = 5'd3;
    localparam logic [OPW-1:0] OP_CLASSIFY = 5'd4;
    localparam logic [OPW-1:0] OP_SQRT_D   = 5'd5;
    localparam logic [OPW-1:0] OP_SQ_R1    = 5'd6;
    localparam logic [OPW-1:0] OP_SQ_R2    = 5'd7;
    localparam logic [OPW-1:0] OP_DIV_A    = 5'd8;
    localparam logic [OPW-1:0] OP_SQ_A     = 5'd9;
    localparam logic [OPW-1:0] OP_SQRT_H   = 5'd10;
    localparam logic [OPW-1:0] OP_MUL_AX   = 5'd11;
    localparam logic [OPW-1:0] OP_MUL_AY   = 5'd12;
    localparam logic [OPW-1:0] OP_MUL_HX   = 5'd13;
    localparam logic [OPW-1:0] OP_MUL_HY   = 5'd14;
    localparam logic [OPW-1:0] OP_DIV_S1X  = 5'd15;
    localparam logic [OPW-1:0] OP_DIV_S1Y  = 5'd16;
    localparam logic [OPW-1:0] OP_DIV_S2X  = 5'd17;
    localparam logic [OPW-1:0] OP_DIV_S2Y  = 5'd18;
    localparam logic [OPW-1:0] OP_DST_1X   = 5'd19;
    localparam logic [OPW-1:0] OP_DST_1Y   = 5'd20;
    localparam logic [OPW-1:0] OP_DST_2X   = 5'd21;
    localparam logic [OPW-1:0] OP_DST_2Y   = 5'd22;
    localparam logic [OPW-1:0] OP_FINISH   = 5'd23;

    localparam logic [1:0] STAT_OK    = 2'd0;
    localparam logic [1:0] STAT_FAR   = 2'd1;
    localparam logic [1:0] STAT_CLOSE = 2'd2;
    localparam logic [1:0] STAT_COINC = 2'd3;

    typedef struct packed {
        logic           load;
        logic           run;
        logic           start;
        logic [OPW-1:0] op;
    } cmd_t;

    typedef struct packed {
        logic done;
        logic err;
        logic tangent;
    } stat_t;

endpackage
`default_nettype wire

@@ sv/ccnp_mul.sv @@
`default_nettype none
// ============================================================================
// ccnp_mul
// Unsigned multiplier, two half-width partial products one after the other.
// ============================================================================
module ccnp_mul (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     start,
    input  logic [ccnp_pkg::MW-1:0]  a,
    input  logic [ccnp_pkg::MW-1:0]  b,
    output logic                     done,
    output logic [ccnp_pkg::PW-1:0]  prod
);
    import ccnp_pkg::*;

    localparam int HW = MW / 2;

    logic              busy_reg;
    logic              ph_reg;
    logic              done_reg;
    logic [PW-1:0]     acc_reg;
    logic [HW-1:0]     a_half;
    logic [MW+HW-1:0]  pp;

    assign a_half = ph_reg ? a[MW-1:HW] : a[HW-1:0];
    assign pp     = (MW+HW)'(a_half) * (MW+HW)'(b);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            ph_reg   <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                ph_reg   <= 1'b0;
            end else if (busy_reg) begin
                ph_reg <= 1'b1;
                if (ph_reg) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (busy_reg) begin
            if (ph_reg) begin
                acc_reg <= acc_reg + (PW'(pp) << HW);
            end else begin
                acc_reg <= PW'(pp);
            end
        end
    end

    assign done = done_reg;
    assign prod = acc_reg;

endmodule
`default_nettype wire

@@ sv/ccnp_iter.sv @@
`default_nettype none
// ============================================================================
// ccnp_iter
// Shared iterative unit: rounded square root (two bits a step) or restoring
// division (one quotient bit a step).
// ============================================================================
module ccnp_iter (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     start,
    input  logic                     sqrt_mode,
    input  logic [ccnp_pkg::NW-1:0]  val,
    input  logic [ccnp_pkg::DVW:0]   dvs,
    output logic                     done,
    output logic [ccnp_pkg::QW-1:0]  res
);
    import ccnp_pkg::*;

    localparam int RMW  = QW + 2;
    localparam int CNTW = $clog2(QW + 1);

    logic            busy_reg;
    logic            fin_reg;
    logic            mode_reg;
    logic [CNTW-1:0] cnt_reg;
    logic [NW-1:0]   sh_reg;
    logic [RMW-1:0]  rem_reg;
    logic [QW-1:0]   root_reg;
    logic [DVW:0]    dvs_reg;

    logic [RMW-1:0]  rem_sh;
    logic [RMW-1:0]  trial;
    logic            take;

    always_comb begin
        if (mode_reg) begin
            rem_sh = {rem_reg[RMW-3:0], sh_reg[NW-1:NW-2]};
            trial  = {root_reg, 2'b01};
        end else begin
            rem_sh = {rem_reg[RMW-2:0], sh_reg[NW-1]};
            trial  = RMW'(dvs_reg);
        end
        take = (rem_sh >= trial);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            fin_reg  <= 1'b0;
        end else begin
            fin_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
            end else if (busy_reg && cnt_reg == CNTW'(1)) begin
                busy_reg <= 1'b0;
                fin_reg  <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            mode_reg <= sqrt_mode;
            dvs_reg  <= dvs;
            root_reg <= '0;
            if (sqrt_mode) begin
                sh_reg  <= val;
                rem_reg <= '0;
                cnt_reg <= CNTW'(NW / 2);
            end else begin
                sh_reg  <= {val[QW-1:0], (NW-QW)'(0)};
                rem_reg <= RMW'(val[NW-1:QW]);
                cnt_reg <= CNTW'(QW);
            end
        end else if (busy_reg) begin
            cnt_reg  <= cnt_reg - CNTW'(1);
            sh_reg   <= mode_reg ? (sh_reg << 2) : (sh_reg << 1);
            rem_reg  <= take ? rem_sh - trial : rem_sh;
            root_reg <= {root_reg[QW-2:0], take};
        end
    end

    // The square root rounds up when the remainder exceeds the root.
    assign res  = (mode_reg && rem_reg > RMW'(root_reg)) ? root_reg + QW'(1) : root_reg;
    assign done = fin_reg;

endmodule
`default_nettype wire

@@ sv/ccnp_controller.sv @@
`default_nettype none
// ============================================================================
// ccnp_controller
// Sequencer: steps the datapath through its operations for one item.
// ============================================================================
module ccnp_controller (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    output ccnp_pkg::cmd_t        cmd,
    input  ccnp_pkg::stat_t       stat
);
    import ccnp_pkg::*;

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_RUN  = 1'b1;

    logic           state_reg;
    logic [OPW-1:0] op_reg;
    logic           started_reg;

    function automatic logic [OPW-1:0] next_op(input logic [OPW-1:0] op,
                                              input logic err, input logic tan);
        logic [OPW-1:0] n;
        n = OP_FINISH;
        unique case (op)
            OP_CLASSIFY: n = err ? OP_FINISH : OP_SQRT_D;
            OP_DIV_A:    n = tan ? OP_MUL_AX : OP_SQ_A;
            OP_DIV_S1Y:  n = tan ? OP_FINISH : OP_DIV_S2X;
            OP_DST_2Y:   n = OP_FINISH;
            default:     n = op + OPW'(1);
        endcase
        return n;
    endfunction

    assign s_ready   = (state_reg == ST_IDLE);
    assign cmd.load  = s_valid && s_ready;
    assign cmd.run   = (state_reg == ST_RUN);
    assign cmd.start = (state_reg == ST_RUN) && !started_reg;
    assign cmd.op    = op_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            op_reg      <= OP_SQ_DX;
            started_reg <= 1'b0;
        end else begin
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_valid) begin
                        state_reg   <= ST_RUN;
                        op_reg      <= OP_SQ_DX;
                        started_reg <= 1'b0;
                    end
                end
                ST_RUN: begin
                    started_reg <= 1'b1;
                    if (stat.done) begin
                        started_reg <= 1'b0;
                        if (op_reg == OP_FINISH) begin
                            state_reg <= ST_IDLE;
                        end else begin
                            op_reg <= next_op(op_reg, stat.err, stat.tangent);
                        end
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

endmodule
`default_nettype wire

@@ sv/ccnp_datapath.sv @@
`default_nettype none
// ============================================================================
// ccnp_datapath
// Operand registers, the shared multiplier and iterative unit, the candidate
// points, the selection and the result register.
// ============================================================================
module ccnp_datapath (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  ccnp_pkg::cmd_t                  cmd,
    output ccnp_pkg::stat_t                 stat,
    input  logic signed [ccnp_pkg::CW-1:0]  s_old_x,
    input  logic signed [ccnp_pkg::CW-1:0]  s_old_y,
    input  logic signed [ccnp_pkg::CW-1:0]  s_first_x,
    input  logic signed [ccnp_pkg::CW-1:0]  s_first_y,
    input  logic signed [ccnp_pkg::CW-1:0]  s_second_x,
    input  logic signed [ccnp_pkg::CW-1:0]  s_second_y,
    input  logic [ccnp_pkg::RW-1:0]         s_first_radius,
    input  logic [ccnp_pkg::RW-1:0]         s_second_radius,
    input  logic                            s_first_is_distance,
    input  logic                            s_second_is_distance,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic signed [ccnp_pkg::CW-1:0]  m_new_x,
    output logic signed [ccnp_pkg::CW-1:0]  m_new_y,
    output logic [1:0]                      m_status,
    output logic [1:0]                      m_solutions_found,
    output logic [ccnp_pkg::TW-1:0]         m_solution_total
);
    import ccnp_pkg::*;

    // Operand registers.
    logic signed [CW-1:0]  old_x_reg, old_y_reg, x1_reg, y1_reg;
    logic signed [DXW-1:0] dx_reg, dy_reg;
    logic [RW-1:0]         r1_reg, r2_reg;

    // Intermediate results.
    logic [DW-1:0]         d2_reg;
    logic [SQW-1:0]        sumsq_reg, diffsq_reg;
    logic [1:0]            status_reg;
    logic                  tangent_reg;
    logic [DVW-1:0]        d_reg;
    logic [RSQW-1:0]       r1sq_reg, hrad_reg;
    logic signed [NW:0]    nn_reg;
    logic [RW-1:0]         am_reg, h_reg;
    logic                  a_neg_reg;
    logic signed [NW-1:0]  ax_reg, ay_reg, hx_reg, hy_reg;
    logic signed [SW-1:0]  s1x_reg, s1y_reg, s2x_reg, s2y_reg;
    logic [PW-1:0]         dacc_reg;
    logic [DSW-1:0]        dist1_reg, dist2_reg;

    // Result register and running total.
    logic                  m_valid_reg;
    logic signed [CW-1:0]  new_x_reg, new_y_reg;
    logic [1:0]            m_status_reg, nsol_reg;
    logic [TW-1:0]         total_reg;

    // Unit connections.
    logic                  mul_start, mul_done;
    logic [MW-1:0]         mul_a, mul_b;
    logic [PW-1:0]         mul_prod;
    logic                  iter_start, iter_done, iter_sqrt;
    logic [NW-1:0]         iter_val;
    logic [DVW:0]          iter_dvs;
    logic [QW-1:0]         iter_res;

    // Derived values.
    logic [DXW-1:0]        adx, ady;
    logic                  dx_neg, dy_neg;
    logic [RW:0]           rsum;
    logic [RW-1:0]         rdiff;
    logic [NW-1:0]         nn_mag;
    logic signed [NW:0]    num;
    logic [NW-1:0]         num_mag;
    logic signed [CW-1:0]  ds_base;
    logic signed [SW-1:0]  ds_pt;
    logic signed [MW:0]    ex;
    logic [MW-1:0]         ex_mag;
    logic                  is_mul, is_iter, out_free, finish;
    logic                  err;

    function automatic logic [NW-1:0] sgn_prod(input logic [PW-1:0] p, input logic neg);
        return neg ? NW'(-p[NW-1:0]) : p[NW-1:0];
    endfunction

    function automatic logic [CW-1:0] sat(input logic signed [SW-1:0] v);
        logic [CW-1:0] r;
        if (&v[SW-1:CW-1] || ~|v[SW-1:CW-1]) begin
            r = v[CW-1:0];
        end else if (v[SW-1]) begin
            r = {1'b1, (CW-1)'(0)};
        end else begin
            r = {1'b0, {(CW-1){1'b1}}};
        end
        return r;
    endfunction

    assign dx_neg = dx_reg[DXW-1];
    assign dy_neg = dy_reg[DXW-1];
    assign adx    = dx_neg ? DXW'(-dx_reg) : DXW'(dx_reg);
    assign ady    = dy_neg ? DXW'(-dy_reg) : DXW'(dy_reg);
    assign rsum   = (RW+1)'(r1_reg) + (RW+1)'(r2_reg);
    assign rdiff  = (r1_reg > r2_reg) ? r1_reg - r2_reg : r2_reg - r1_reg;
    assign nn_mag = nn_reg[NW] ? NW'(-nn_reg) : NW'(nn_reg);
    assign num_mag = num[NW] ? NW'(-num) : NW'(num);
    assign ex      = (MW+1)'(ds_base) - (MW+1)'(ds_pt);
    assign ex_mag  = ex[MW] ? MW'(-ex) : MW'(ex);
    assign err     = (status_reg != STAT_OK);

    // Operand selection for the multiplier, the divider and the distances.
    always_comb begin
        mul_a   = '0;
        mul_b   = '0;
        is_mul  = 1'b1;
        unique case (cmd.op)
            OP_SQ_DX:   begin mul_a = MW'(adx);   mul_b = MW'(adx);   end
            OP_SQ_DY:   begin mul_a = MW'(ady);   mul_b = MW'(ady);   end
            OP_SQ_SUM:  begin mul_a = MW'(rsum);  mul_b = MW'(rsum);  end
            OP_SQ_DIFF: begin mul_a = MW'(rdiff); mul_b = MW'(rdiff); end
            OP_SQ_R1:   begin mul_a = MW'(r1_reg); mul_b = MW'(r1_reg); end
            OP_SQ_R2:   begin mul_a = MW'(r2_reg); mul_b = MW'(r2_reg); end
            OP_SQ_A:    begin mul_a = MW'(am_reg); mul_b = MW'(am_reg); end
            OP_MUL_AX:  begin mul_a = MW'(am_reg); mul_b = MW'(adx);    end
            OP_MUL_AY:  begin mul_a = MW'(am_reg); mul_b = MW'(ady);    end
            OP_MUL_HX:  begin mul_a = MW'(h_reg);  mul_b = MW'(adx);    end
            OP_MUL_HY:  begin mul_a = MW'(h_reg);  mul_b = MW'(ady);    end
            OP_DST_1X, OP_DST_1Y, OP_DST_2X, OP_DST_2Y: begin
                mul_a = ex_mag;
                mul_b = ex_mag;
            end
            default:    is_mul = 1'b0;
        endcase
    end

    always_comb begin
        num = '0;
        unique case (cmd.op)
            OP_DIV_S1X: num = (NW+1)'(ax_reg) - (NW+1)'(hy_reg);
            OP_DIV_S1Y: num = (NW+1)'(ay_reg) + (NW+1)'(hx_reg);
            OP_DIV_S2X: num = (NW+1)'(ax_reg) + (NW+1)'(hy_reg);
            OP_DIV_S2Y: num = (NW+1)'(ay_reg) - (NW+1)'(hx_reg);
            default:    num = '0;
        endcase
    end

    always_comb begin
        ds_base = old_x_reg;
        ds_pt   = s1x_reg;
        unique case (cmd.op)
            OP_DST_1Y: begin ds_base = old_y_reg; ds_pt = s1y_reg; end
            OP_DST_2X: begin ds_base = old_x_reg; ds_pt = s2x_reg; end
            OP_DST_2Y: begin ds_base = old_y_reg; ds_pt = s2y_reg; end
            default:   begin ds_base = old_x_reg; ds_pt = s1x_reg; end
        endcase
    end

    always_comb begin
        iter_sqrt = 1'b0;
        iter_val  = '0;
        iter_dvs  = '0;
        is_iter   = 1'b1;
        unique case (cmd.op)
            OP_SQRT_D: begin
                iter_sqrt = 1'b1;
                iter_val  = d2_reg[NW-1:0];
            end
            OP_SQRT_H: begin
                iter_sqrt = 1'b1;
                iter_val  = NW'(hrad_reg);
            end
            OP_DIV_A: begin
                // Divisor 2d, so half the divisor is d.
                iter_val = nn_mag + NW'(d_reg);
                iter_dvs = {d_reg, 1'b0};
            end
            OP_DIV_S1X, OP_DIV_S1Y, OP_DIV_S2X, OP_DIV_S2Y: begin
                iter_val = num_mag + NW'(d_reg >> 1);
                iter_dvs = {1'b0, d_reg};
            end
            default: is_iter = 1'b0;
        endcase
    end

    assign mul_start  = cmd.start && is_mul;
    assign iter_start = cmd.start && is_iter;
    assign out_free   = !m_valid_reg || m_ready;
    assign finish     = cmd.run && (cmd.op == OP_FINISH) && out_free;

    always_comb begin
        stat.err     = err;
        stat.tangent = tangent_reg;
        if (is_mul) begin
            stat.done = cmd.run && mul_done;
        end else if (is_iter) begin
            stat.done = cmd.run && iter_done;
        end else if (cmd.op == OP_FINISH) begin
            stat.done = finish;
        end else begin
            // Steps that use neither unit report done once their registers have settled.
            stat.done = cmd.run && !cmd.start;
        end
    end

    ccnp_mul u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mul_start),
        .a       (mul_a),
        .b       (mul_b),
        .done    (mul_done),
        .prod    (mul_prod)
    );

    ccnp_iter u_iter (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (iter_start),
        .sqrt_mode (iter_sqrt),
        .val       (iter_val),
        .dvs       (iter_dvs),
        .done      (iter_done),
        .res       (iter_res)
    );

    // Payload registers of the working item.
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            old_x_reg <= s_old_x;
            old_y_reg <= s_old_y;
            x1_reg    <= s_first_x;
            y1_reg    <= s_first_y;
            dx_reg    <= DXW'(s_second_x) - DXW'(s_first_x);
            dy_reg    <= DXW'(s_second_y) - DXW'(s_first_y);
            r1_reg    <= s_first_is_distance ? s_first_radius : '0;
            r2_reg    <= s_second_is_distance ? s_second_radius : '0;
        end
        if (cmd.start && cmd.op == OP_CLASSIFY) begin
            h_reg <= '0;
        end
        if (mul_done) begin
            unique case (cmd.op)
                OP_SQ_DX:   d2_reg     <= DW'(mul_prod);
                OP_SQ_DY:   d2_reg     <= d2_reg + DW'(mul_prod);
                OP_SQ_SUM:  sumsq_reg  <= mul_prod[SQW-1:0];
                OP_SQ_DIFF: diffsq_reg <= mul_prod[SQW-1:0];
                OP_SQ_R1:   r1sq_reg   <= mul_prod[RSQW-1:0];
                OP_SQ_R2:   nn_reg     <= (NW+1)'(r1sq_reg) + (NW+1)'(d2_reg[SQW-1:0])
                                          - (NW+1)'(mul_prod[RSQW-1:0]);
                OP_SQ_A:    hrad_reg   <= r1sq_reg - mul_prod[RSQW-1:0];
                OP_MUL_AX:  ax_reg     <= sgn_prod(mul_prod, a_neg_reg ^ dx_neg);
                OP_MUL_AY:  ay_reg     <= sgn_prod(mul_prod, a_neg_reg ^ dy_neg);
                OP_MUL_HX:  hx_reg     <= sgn_prod(mul_prod, dx_neg);
                OP_MUL_HY:  hy_reg     <= sgn_prod(mul_prod, dy_neg);
                OP_DST_1X:  dacc_reg   <= mul_prod;
                OP_DST_1Y:  dist1_reg  <= DSW'(dacc_reg) + DSW'(mul_prod);
                OP_DST_2X:  dacc_reg   <= mul_prod;
                OP_DST_2Y:  dist2_reg  <= DSW'(dacc_reg) + DSW'(mul_prod);
                default:    dacc_reg   <= dacc_reg;
            endcase
        end
        if (iter_done) begin
            unique case (cmd.op)
                OP_SQRT_D: d_reg <= iter_res[DVW-1:0];
                OP_SQRT_H: h_reg <= iter_res[RW-1:0];
                OP_DIV_A: begin
                    // The distance along the centre line never exceeds the radius.
                    am_reg    <= (iter_res > QW'(r1_reg)) ? r1_reg : iter_res[RW-1:0];
                    a_neg_reg <= nn_reg[NW];
                end
                OP_DIV_S1X: s1x_reg <= num[NW] ? SW'(x1_reg) - SW'(iter_res)
                                               : SW'(x1_reg) + SW'(iter_res);
                OP_DIV_S1Y: s1y_reg <= num[NW] ? SW'(y1_reg) - SW'(iter_res)
                                               : SW'(y1_reg) + SW'(iter_res);
                OP_DIV_S2X: s2x_reg <= num[NW] ? SW'(x1_reg) - SW'(iter_res)
                                               : SW'(x1_reg) + SW'(iter_res);
                OP_DIV_S2Y: s2y_reg <= num[NW] ? SW'(y1_reg) - SW'(iter_res)
                                               : SW'(y1_reg) + SW'(iter_res);
                default:    d_reg <= d_reg;
            endcase
        end
        if (finish) begin
            if (err) begin
                new_x_reg <= '0;
                new_y_reg <= '0;
            end else if (tangent_reg || dist1_reg < dist2_reg) begin
                new_x_reg <= sat(s1x_reg);
                new_y_reg <= sat(s1y_reg);
            end else begin
                new_x_reg <= sat(s2x_reg);
                new_y_reg <= sat(s2y_reg);
            end
            m_status_reg <= status_reg;
            nsol_reg     <= err ? 2'd0 : (tangent_reg ? 2'd1 : 2'd2);
        end
    end

    // Classification, the running total and the result handshake.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            status_reg  <= STAT_OK;
            tangent_reg <= 1'b0;
            total_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cmd.start && cmd.op == OP_CLASSIFY) begin
                if (d2_reg > DW'(sumsq_reg)) begin
                    status_reg <= STAT_FAR;
                end else if (d2_reg < DW'(diffsq_reg)) begin
                    status_reg <= STAT_CLOSE;
                end else if (d2_reg == '0) begin
                    status_reg <= STAT_COINC;
                end else begin
                    status_reg <= STAT_OK;
                end
                tangent_reg <= (d2_reg == DW'(sumsq_reg)) || (d2_reg == DW'(diffsq_reg));
            end
            if (finish) begin
                m_valid_reg <= 1'b1;
                if (!err) begin
                    if ((TW+1)'(total_reg) + (TW+1)'(tangent_reg ? 2'd1 : 2'd2)
                        > (TW+1)'({TW{1'b1}})) begin
                        total_reg <= '1;
                    end else begin
                        total_reg <= total_reg + TW'(tangent_reg ? 2'd1 : 2'd2);
                    end
                end
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign m_valid           = m_valid_reg;
    assign m_new_x           = new_x_reg;
    assign m_new_y           = new_y_reg;
    assign m_status          = m_status_reg;
    assign m_solutions_found = nsol_reg;
    assign m_solution_total  = total_reg;

endmodule
`default_nettype wire

@@ sv/circle_circle_nearest_point.sv @@
`default_nettype none
// ============================================================================
// circle_circle_nearest_point
// Nearer meeting point of two circles, signed Q16.16 coordinates.
// ============================================================================
// The block takes one beat holding two circle centres, two radii with their
// distance flags and the old position of a point, and returns one beat with
// the meeting point of the two circles that lies nearer the old position,
// the status, the number of meeting points and a saturating running count of
// points found. A radius whose flag is clear is taken as zero. When the
// centres are too far apart, too close or coincident, the coordinates and
// the count of points are zero and the running count is left alone.
// Items are processed one at a time: s_ready is high only while the block
// is idle. An item is not finished while the previous result still waits
// for m_ready. The shared iterative unit forms the centre distance and the
// chord half-length by square roots of one result bit a cycle, and the
// distance along the centre line and the four point coordinates by
// divisions of one quotient bit a cycle; the products go through one
// shared multiplier. The result is held in an output register, so a new
// item can be accepted while the previous result still waits for m_ready.
// ============================================================================
module circle_circle_nearest_point (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic signed [ccnp_pkg::CW-1:0]  s_old_x,
    input  logic signed [ccnp_pkg::CW-1:0]  s_old_y,
    input  logic signed [ccnp_pkg::CW-1:0]  s_first_x,
    input  logic signed [ccnp_pkg::CW-1:0]  s_first_y,
    input  logic signed [ccnp_pkg::CW-1:0]  s_second_x,
    input  logic signed [ccnp_pkg::CW-1:0]  s_second_y,
    input  logic [ccnp_pkg::RW-1:0]         s_first_radius,
    input  logic [ccnp_pkg::RW-1:0]         s_second_radius,
    input  logic                            s_first_is_distance,
    input  logic                            s_second_is_distance,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic signed [ccnp_pkg::CW-1:0]  m_new_x,
    output logic signed [ccnp_pkg::CW-1:0]  m_new_y,
    output logic [1:0]                      m_status,
    output logic [1:0]                      m_solutions_found,
    output logic [ccnp_pkg::TW-1:0]         m_solution_total
);
    import ccnp_pkg::*;

    // Commands from the sequencer and status back from the datapath.
    cmd_t  cmd;
    stat_t stat;

    ccnp_controller u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .cmd     (cmd),
        .stat    (stat)
    );

    ccnp_datapath u_dp (
        .aclk                 (aclk),
        .aresetn              (aresetn),
        .cmd                  (cmd),
        .stat                 (stat),
        .s_old_x              (s_old_x),
        .s_old_y              (s_old_y),
        .s_first_x            (s_first_x),
        .s_first_y            (s_first_y),
        .s_second_x           (s_second_x),
        .s_second_y           (s_second_y),
        .s_first_radius       (s_first_radius),
        .s_second_radius      (s_second_radius),
        .s_first_is_distance  (s_first_is_distance),
        .s_second_is_distance (s_second_is_distance),
        .m_valid              (m_valid),
        .m_ready              (m_ready),
        .m_new_x              (m_new_x),
        .m_new_y              (m_new_y),
        .m_status             (m_status),
        .m_solutions_found    (m_solutions_found),
        .m_solution_total     (m_solution_total)
    );

endmodule
`default_nettype wire

@@ sv/ccnp_checker.sv @@
`default_nettype none
// ============================================================================
// ccnp_checker
// Port-level checks on the nearest-point block, bound to its top level.
// ============================================================================
module ccnp_checker (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    input  logic                            s_ready,
    input  logic signed [ccnp_pkg::CW-1:0]  s_old_x,
    input  logic signed [ccnp_pkg::CW-1:0]  s_old_y,
    input  logic signed [ccnp_pkg::CW-1:0]  s_first_x,
    input  logic signed [ccnp_pkg::CW-1:0]  s_first_y,
    input  logic signed [ccnp_pkg::CW-1:0]  s_second_x,
    input  logic signed [ccnp_pkg::CW-1:0]  s_second_y,
    input  logic [ccnp_pkg::RW-1:0]         s_first_radius,
    input  logic [ccnp_pkg::RW-1:0]         s_second_radius,
    input  logic                            s_first_is_distance,
    input  logic                            s_second_is_distance,
    input  logic                            m_valid,
    input  logic                            m_ready,
    input  logic signed [ccnp_pkg::CW-1:0]  m_new_x,
    input  logic signed [ccnp_pkg::CW-1:0]  m_new_y,
    input  logic [1:0]                      m_status,
    input  logic [1:0]                      m_solutions_found,
    input  logic [ccnp_pkg::TW-1:0]         m_solution_total
);
    import ccnp_pkg::*;

    // No result beat is offered straight after reset.
    a_reset_quiet: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result offered after reset");

    // A held result beat keeps its payload.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_new_x) && $stable(m_new_y)
                                && $stable(m_solution_total))
        else $error("result beat changed while stalled");

    // An error result carries no point and no solutions.
    a_err_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status != STAT_OK |-> m_new_x == '0 && m_new_y == '0
                                          && m_solutions_found == 2'd0)
        else $error("error result carries a point");

    // A good result has one or two solutions.
    a_ok_count: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status == STAT_OK |-> m_solutions_found == 2'd1
                                         || m_solutions_found == 2'd2)
        else $error("good result without solutions");

    // One item at a time: the block is busy right after accepting an item.
    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("second item accepted while busy");

endmodule

bind circle_circle_nearest_point ccnp_checker u_ccnp_checker (.*);
`default_nettype wire
